// ===== design/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  localparam int REGION_LOG2  = 16;
  localparam int HEADER_BYTES = 16;
  localparam int GRAIN_LOG2   = 4;
  localparam int SLOT_W       = REGION_LOG2 - GRAIN_LOG2;
  localparam int LG_W         = 5;
  localparam int ENTRY_W      = 7;
  localparam int MINB_W       = 17;
  localparam int NEED_W       = (REGION_LOG2 + 2 > 18) ? REGION_LOG2 + 2 : 18;
  localparam int MIN_BLOCK_RESET = 16;

  // table entry bits
  localparam int E_HEAD_BIT = 6;
  localparam int E_USED_BIT = 5;

  typedef enum logic [1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_NOT_USE = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] req_size;
    logic [15:0] offset;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [15:0] block_offset;
    logic [15:0] granted_size;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [SLOT_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } ctrl_res_t;

  function automatic logic [ENTRY_W-1:0] mk_entry(input logic used, input logic [LG_W-1:0] lg);
    mk_entry = {1'b1, used, lg};
  endfunction

  function automatic out_item_t mk_res(input logic ok, input status_t st,
                                       input logic [15:0] off, input logic [15:0] gs);
    out_item_t r;
    r.ok           = ok;
    r.status       = st;
    r.block_offset = off;
    r.granted_size = gs;
    mk_res = r;
  endfunction

endpackage

// ===== design/bba_table.sv =====
`timescale 1ns / 1ps

module bba_table import bba_pkg::*; (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [2**SLOT_W];

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== design/bba_ctrl.sv =====
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [MINB_W-1:0]  cfg_wdata,
  input  logic               res_ready,
  output ctrl_res_t          res,
  output mem_req_t           mreq,
  input  logic [ENTRY_W-1:0] mrdata
);

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_WRD   = 12'b000000000100,
    S_WEV   = 12'b000000001000,
    S_PICK  = 12'b000000010000,
    S_SPLIT = 12'b000000100000,
    S_RRD   = 12'b000001000000,
    S_REV   = 12'b000010000000,
    S_BRD   = 12'b000100000000,
    S_BEV   = 12'b001000000000,
    S_MRG   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  localparam logic [LG_W-1:0] LG_GRAIN  = LG_W'(GRAIN_LOG2);
  localparam logic [LG_W-1:0] LG_REGION = LG_W'(REGION_LOG2);

  state_t             state_r, state_nxt;
  logic [SLOT_W:0]    slot_r, slot_nxt;
  logic [SLOT_W-1:0]  base_r, base_nxt;
  logic [LG_W-1:0]    best_lg_r, best_lg_nxt;
  logic               found_r, found_nxt;
  logic [LG_W-1:0]    lg_r, lg_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic               is_acq_r, is_acq_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [MINB_W-1:0]  min_blk_r;
  out_item_t          res_r, res_nxt;

  logic [LG_W-1:0]    e_lg;
  logic               e_ok;
  logic [NEED_W-1:0]  need2;
  logic [SLOT_W-1:0]  bud_mask;
  logic [SLOT_W-1:0]  bud_slot;
  logic [NEED_W-1:0]  rel_start;
  logic [NEED_W-1:0]  grant_off;
  logic [NEED_W-1:0]  grant_size;

  assign e_lg = mrdata[LG_W-1:0];
  assign e_ok = mrdata[E_HEAD_BIT] && (e_lg >= LG_GRAIN) && (e_lg <= LG_REGION);
  assign need2 = (need_r < NEED_W'(min_blk_r)) ? NEED_W'(min_blk_r) : need_r;
  assign bud_mask = SLOT_W'(1) << (lg_r - LG_GRAIN);
  assign bud_slot = base_r ^ bud_mask;
  assign rel_start = NEED_W'(in_data.offset) - NEED_W'(HEADER_BYTES);
  assign grant_off = {{(NEED_W - SLOT_W - GRAIN_LOG2){1'b0}}, base_r, {GRAIN_LOG2{1'b0}}}
                     + NEED_W'(HEADER_BYTES);
  assign grant_size = (NEED_W'(1) << lg_r) - NEED_W'(HEADER_BYTES);

  assign in_stall  = (state_r != S_IDLE);
  assign res.valid = (state_r == S_DONE);
  assign res.item  = res_r;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    best_lg_nxt   = best_lg_r;
    found_nxt     = found_r;
    lg_nxt        = lg_r;
    need_nxt      = need_r;
    is_acq_nxt    = is_acq_r;
    clr_reply_nxt = clr_reply_r;
    clr_cnt_nxt   = clr_cnt_r;
    res_nxt       = res_r;
    mreq          = '0;

    case (state_r)
      S_CLR: begin
        // sweep the table, seeding slot 0 with the whole region
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = clr_cnt_r;
        mreq.wdata = (clr_cnt_r == '0) ? mk_entry(1'b0, LG_REGION) : '0;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == '1) begin
          res_nxt   = mk_res(1'b1, ST_OK, '0, '0);
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          slot_nxt  = '0;
          found_nxt = 1'b0;
          case (func_t'(in_data.func))
            FUNC_ACQUIRE: begin
              is_acq_nxt = 1'b1;
              if (in_data.req_size == '0) begin
                res_nxt   = mk_res(1'b0, ST_ZERO, '0, '0);
                state_nxt = S_DONE;
              end else begin
                need_nxt  = NEED_W'(in_data.req_size) + NEED_W'(HEADER_BYTES);
                state_nxt = S_WRD;
              end
            end
            FUNC_RELEASE: begin
              if (in_data.offset == '0) begin
                res_nxt   = mk_res(1'b1, ST_OK, '0, '0);
                state_nxt = S_DONE;
              end else if (NEED_W'(in_data.offset) < NEED_W'(HEADER_BYTES) ||
                           NEED_W'(in_data.offset) >= (NEED_W'(1) << REGION_LOG2)) begin
                res_nxt   = mk_res(1'b0, ST_RANGE, '0, '0);
                state_nxt = S_DONE;
              end else if (rel_start[GRAIN_LOG2-1:0] != '0) begin
                res_nxt   = mk_res(1'b0, ST_NOT_USE, '0, '0);
                state_nxt = S_DONE;
              end else begin
                base_nxt  = rel_start[GRAIN_LOG2 +: SLOT_W];
                state_nxt = S_RRD;
              end
            end
            FUNC_CLEAR: begin
              clr_cnt_nxt   = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            default: begin
              is_acq_nxt = 1'b0;
              if (in_data.req_size == '0) begin
                res_nxt   = mk_res(1'b0, ST_ZERO, '0, '0);
                state_nxt = S_DONE;
              end else if (NEED_W'(in_data.req_size) <= NEED_W'(HEADER_BYTES)) begin
                res_nxt   = mk_res(1'b0, ST_NOFIT, '0, '0);
                state_nxt = S_DONE;
              end else begin
                need_nxt  = NEED_W'(in_data.req_size);
                state_nxt = S_WRD;
              end
            end
          endcase
        end
      end
      S_WRD: begin
        if (slot_r[SLOT_W]) begin
          state_nxt = S_PICK;
        end else begin
          mreq.en   = 1'b1;
          mreq.addr = slot_r[SLOT_W-1:0];
          state_nxt = S_WEV;
        end
      end
      S_WEV: begin
        if (!e_ok) begin
          state_nxt = S_PICK;
        end else begin
          if (!mrdata[E_USED_BIT] && need_r <= (NEED_W'(1) << e_lg) &&
              (!found_r || e_lg < best_lg_r)) begin
            found_nxt   = 1'b1;
            best_lg_nxt = e_lg;
            base_nxt    = slot_r[SLOT_W-1:0];
          end
          slot_nxt  = slot_r + ((SLOT_W+1)'(1) << (e_lg - LG_GRAIN));
          state_nxt = S_WRD;
        end
      end
      S_PICK: begin
        state_nxt = S_DONE;
        if (!found_r) begin
          res_nxt = mk_res(1'b0, ST_NOFIT, '0, '0);
        end else if (!is_acq_r) begin
          res_nxt = mk_res(1'b1, ST_OK, '0, '0);
        end else if (need2 > (NEED_W'(1) << best_lg_r)) begin
          res_nxt = mk_res(1'b0, ST_NOFIT, '0, '0);
        end else begin
          need_nxt  = need2;
          lg_nxt    = best_lg_r;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // one halving per cycle, the upper half goes back free
        mreq.en = 1'b1;
        mreq.we = 1'b1;
        if (lg_r > LG_GRAIN && need_r <= (NEED_W'(1) << (lg_r - LG_W'(1)))) begin
          mreq.addr  = base_r + (SLOT_W'(1) << (lg_r - LG_W'(GRAIN_LOG2 + 1)));
          mreq.wdata = mk_entry(1'b0, lg_r - LG_W'(1));
          lg_nxt     = lg_r - LG_W'(1);
        end else begin
          mreq.addr  = base_r;
          mreq.wdata = mk_entry(1'b1, lg_r);
          res_nxt    = mk_res(1'b1, ST_OK, grant_off[15:0], grant_size[15:0]);
          state_nxt  = S_DONE;
        end
      end
      S_RRD: begin
        mreq.en   = 1'b1;
        mreq.addr = base_r;
        state_nxt = S_REV;
      end
      S_REV: begin
        if (!e_ok || !mrdata[E_USED_BIT]) begin
          res_nxt   = mk_res(1'b0, ST_NOT_USE, '0, '0);
          state_nxt = S_DONE;
        end else begin
          mreq.en    = 1'b1;
          mreq.we    = 1'b1;
          mreq.addr  = base_r;
          mreq.wdata = mk_entry(1'b0, e_lg);
          lg_nxt     = e_lg;
          state_nxt  = S_BRD;
        end
      end
      S_BRD: begin
        if (lg_r >= LG_REGION) begin
          res_nxt   = mk_res(1'b1, ST_OK, '0, '0);
          state_nxt = S_DONE;
        end else begin
          mreq.en   = 1'b1;
          mreq.addr = bud_slot;
          state_nxt = S_BEV;
        end
      end
      S_BEV: begin
        if (!mrdata[E_HEAD_BIT] || mrdata[E_USED_BIT] || e_lg != lg_r) begin
          res_nxt   = mk_res(1'b1, ST_OK, '0, '0);
          state_nxt = S_DONE;
        end else begin
          // drop the header of whichever half is upper
          mreq.en    = 1'b1;
          mreq.we    = 1'b1;
          mreq.wdata = '0;
          if ((base_r & bud_mask) != '0) begin
            mreq.addr = base_r;
            base_nxt  = bud_slot;
          end else begin
            mreq.addr = bud_slot;
          end
          lg_nxt    = lg_r + LG_W'(1);
          state_nxt = S_MRG;
        end
      end
      S_MRG: begin
        mreq.en    = 1'b1;
        mreq.we    = 1'b1;
        mreq.addr  = base_r;
        mreq.wdata = mk_entry(1'b0, lg_r);
        state_nxt  = S_BRD;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      min_blk_r   <= MINB_W'(MIN_BLOCK_RESET);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= (state_nxt == S_CLR) ? clr_reply_nxt : 1'b0;
      if (cfg_we) begin
        min_blk_r <= (cfg_wdata < MINB_W'(MIN_BLOCK_RESET)) ? MINB_W'(MIN_BLOCK_RESET)
                                                            : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    base_r    <= base_nxt;
    best_lg_r <= best_lg_nxt;
    found_r   <= found_nxt;
    lg_r      <= lg_nxt;
    need_r    <= need_nxt;
    is_acq_r  <= is_acq_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== design/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Buddy block allocator over a 64 KiB region, 16-byte header per block.
// Input channel in_valid/in_stall/in_data carries one command item
// (acquire, release, clear, query); output channel out_valid/out_stall/
// out_data returns exactly one result item per command.
// cfg_we/cfg_wdata write min_block; the user is to write it only while
// the block is idle, which the block itself does not enforce. Reset
// (synchronous, rst_n low) sets min_block to 16 and starts a clearing
// pass over the 4096-entry block table, with in_stall high throughout.
// Argument errors go straight to the result; acquire and query walk the
// block table, reading then evaluating each block visited, and acquire
// then splits the chosen block; a release frees its block, then merges it
// with its buddy level by level. Clear sweeps the table. The single-port
// table memory allows one access per cycle. One command is in work at a
// time; a new item is taken as soon as the sequencer is idle, even while
// the last result still sits in the output register. If the receiver
// stalls, the result holds in out_data and the next command, once done, waits behind it.
module buddy_block_allocator import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [MINB_W-1:0] cfg_wdata
);

  mem_req_t           mreq;
  logic [ENTRY_W-1:0] mrdata;
  ctrl_res_t          res;
  logic               res_ready;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // output slot frees when empty or being taken this cycle
  assign res_ready = !out_valid_r || !out_stall;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_ready (res_ready),
    .res       (res),
    .mreq      (mreq),
    .mrdata    (mrdata)
  );

  bba_table u_table (
    .clk   (clk),
    .req   (mreq),
    .rdata (mrdata)
  );

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/bba_checker.sv =====
`timescale 1ns / 1ps

module bba_checker import bba_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ok == (out_data.status == ST_OK)))
    else $error("ok and status disagree");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.block_offset == '0 && out_data.granted_size == '0)
    else $error("failed item carries a grant");

  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.block_offset[3:0] == '0 && out_data.granted_size[3:0] == '0)
    else $error("grant not on a 16-byte grain");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
